// File: design/bmvr_pkg.sv
// Package for the banded motor voltage regulator.
// Commands, band thresholds, setpoint tables and the control-step struct.
// No dependencies.
package bmvr_pkg;

  localparam int WINDOW_DEF = 30;
  localparam int LEVELS = 11;
  localparam logic [15:0] PERIOD_RESET = 16'd2096;

  typedef enum logic [1:0] {
    CMD_SAMPLE = 2'd0,
    CMD_TICK   = 2'd1,
    CMD_TARGET = 2'd2
  } cmd_t;

  // thresholds in ADC code x16: 0.8, 0.5, 0.2, 0.1, 0.05 V
  localparam logic signed [16:0] T08  = 17'sd17476;
  localparam logic signed [16:0] T05  = 17'sd10922;
  localparam logic signed [16:0] T02  = 17'sd4369;
  localparam logic signed [16:0] T01  = 17'sd2184;
  localparam logic signed [16:0] T005 = 17'sd1092;

  localparam logic [6:0] STEP_BIG  = 7'd100;
  localparam logic [6:0] STEP_MID  = 7'd50;
  localparam logic [6:0] STEP_FINE = 7'd1;

  localparam logic [10:0] GOAL_TABLE [16] = '{
    11'd0, 11'd734, 11'd839, 11'd945, 11'd1049, 11'd1153, 11'd1258, 11'd1363,
    11'd1468, 11'd1573, 11'd1678, 11'd1678, 11'd1678, 11'd1678, 11'd1678, 11'd1678
  };

  localparam logic [15:0] VOLT_TABLE [16] = '{
    16'd0, 16'd10923, 16'd15729, 16'd20753, 16'd25122, 16'd29273, 16'd33205,
    16'd37137, 16'd40414, 16'd43254, 16'd45438, 16'd45438, 16'd45438,
    16'd45438, 16'd45438, 16'd45438
  };

  typedef struct packed {
    logic [15:0] period;
    logic [10:0] goal;
    logic [15:0] target;
    logic [15:0] mean;
    logic [15:0] duty;
  } ctrl_in_t;

endpackage

// File: design/banded_motor_voltage_regulator_core.sv
// Banded motor voltage regulator, top level.
// Depends on bmvr_pkg and bmvr_ctrl_step.
//
// Usage:
//   in_*  : one transaction per command. in_tuser = command (0 ADC sample,
//           1 control tick, 2 set target level then control step).
//   out_* : exactly one result per input transaction: current duty and
//           the latest WINDOW-sample mean (ADC code x16).
//   cfg_* : writes pwm_period; always ready, write only while idle.
// The result is registered and presented in the cycle after the input.
// One transaction per cycle while the output is not stalled; state update,
// mean division (reciprocal multiply) and control step are combinational.
// The output register frees when out_tready is high, so a new input is
// taken in the same cycle the previous result leaves.
// Receiver stall: out_tvalid and out_tdata hold, in_tready drops.
// Reset (rst_n low, synchronous): duty, mean, accumulator, goal and
// target clear to zero, pwm_period returns to 2096, no result pending.
module banded_motor_voltage_regulator_core #(
  parameter int WINDOW = bmvr_pkg::WINDOW_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // adc_code[11:0], target_level[15:12]
  input  logic [1:0]  in_tuser,   // command[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // duty[15:0], mean_level[31:16]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);
  import bmvr_pkg::*;

  localparam int SUM_W  = $clog2(WINDOW * 4095 + 1);
  localparam int CNT_W  = $clog2(WINDOW + 1);
  localparam int NUM_W  = SUM_W + 4;
  localparam int SHIFT  = NUM_W + $clog2(WINDOW);
  localparam int MULT_W = NUM_W + 2;
  localparam logic [63:0] MULT_FULL =
    ((64'd1 << SHIFT) + 64'(WINDOW) - 64'd1) / 64'(WINDOW);
  localparam logic [MULT_W-1:0] MULT = MULT_FULL[MULT_W-1:0];

  logic [15:0]      period_r;
  logic [SUM_W-1:0] sum_r, sum_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [15:0]      mean_r, mean_nxt;
  logic [15:0]      duty_r, duty_nxt;
  logic [10:0]      goal_r, goal_nxt;
  logic [15:0]      target_r, target_nxt;
  logic             out_valid_r;
  logic [31:0]      out_data_r;

  logic [11:0]             adc_code;
  logic [3:0]              level;
  logic                    in_xact;
  logic [SUM_W-1:0]        sum_inc;
  logic [CNT_W-1:0]        cnt_inc;
  logic [NUM_W+MULT_W-1:0] prod;
  logic                    level_ok;
  ctrl_in_t                ctl;
  logic [15:0]             step_duty;

  assign adc_code  = in_tdata[11:0];
  assign level     = in_tdata[15:12];
  assign in_tready = !out_valid_r || out_tready;
  assign in_xact   = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  assign sum_inc  = sum_r + {{(SUM_W-12){1'b0}}, adc_code};
  assign cnt_inc  = cnt_r + {{(CNT_W-1){1'b0}}, 1'b1};
  assign prod     = {sum_inc, 4'd0} * MULT;
  assign level_ok = {1'b0, level} < 5'(LEVELS);

  always_comb begin
    ctl.period = period_r;
    ctl.mean   = mean_r;
    ctl.duty   = duty_r;
    if (cmd_t'(in_tuser) == CMD_TARGET) begin
      ctl.goal   = GOAL_TABLE[level];
      ctl.target = VOLT_TABLE[level];
    end else begin
      ctl.goal   = goal_r;
      ctl.target = target_r;
    end
  end

  bmvr_ctrl_step u_step (
    .ctl_i  (ctl),
    .duty_o (step_duty)
  );

  always_comb begin
    sum_nxt    = sum_r;
    cnt_nxt    = cnt_r;
    mean_nxt   = mean_r;
    duty_nxt   = duty_r;
    goal_nxt   = goal_r;
    target_nxt = target_r;
    case (cmd_t'(in_tuser))
      CMD_SAMPLE: begin
        if (cnt_inc >= CNT_W'(WINDOW)) begin
          mean_nxt = prod[SHIFT +: 16];
          sum_nxt  = '0;
          cnt_nxt  = '0;
        end else begin
          sum_nxt = sum_inc;
          cnt_nxt = cnt_inc;
        end
      end
      CMD_TICK: begin
        duty_nxt = step_duty;
      end
      CMD_TARGET: begin
        if (level_ok) begin
          goal_nxt   = ctl.goal;
          target_nxt = ctl.target;
          duty_nxt   = step_duty;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r    <= PERIOD_RESET;
      sum_r       <= '0;
      cnt_r       <= '0;
      mean_r      <= '0;
      duty_r      <= '0;
      goal_r      <= '0;
      target_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        period_r <= cfg_data;
      end
      if (in_xact) begin
        sum_r       <= sum_nxt;
        cnt_r       <= cnt_nxt;
        mean_r      <= mean_nxt;
        duty_r      <= duty_nxt;
        goal_r      <= goal_nxt;
        target_r    <= target_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xact) begin
      out_data_r <= {mean_nxt, duty_nxt};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// File: design/bmvr_ctrl_step.sv
// Banded control step: next duty from target, mean, goal and current duty.
// Depends on bmvr_pkg.
module bmvr_ctrl_step (
  input  bmvr_pkg::ctrl_in_t ctl_i,
  output logic [15:0]        duty_o
);
  import bmvr_pkg::*;

  logic signed [16:0] diff;
  logic               down_ok;
  logic [15:0]        goal_ext;
  logic [15:0]        half_up;
  logic [15:0]        half_dn;
  logic [6:0]         step;
  logic               step_dn;
  logic               step_en;
  logic signed [17:0] cand;
  logic [15:0]        stepped;

  assign diff     = $signed({1'b0, ctl_i.target}) - $signed({1'b0, ctl_i.mean});
  assign down_ok  = ctl_i.target != 16'd0;
  assign goal_ext = {5'd0, ctl_i.goal};
  assign half_up  = (goal_ext >= ctl_i.period) ? ctl_i.period
                    : goal_ext + ((ctl_i.period - goal_ext) >> 1);
  assign half_dn  = ({6'd0, ctl_i.goal[10:1]} > ctl_i.period) ? ctl_i.period
                    : {6'd0, ctl_i.goal[10:1]};

  assign cand = step_dn ? $signed({2'b00, ctl_i.duty}) - $signed({11'd0, step})
                        : $signed({2'b00, ctl_i.duty}) + $signed({11'd0, step});

  always_comb begin
    if (cand < 18'sd0) begin
      stepped = 16'd0;
    end else if (cand > $signed({2'b00, ctl_i.period})) begin
      stepped = ctl_i.period;
    end else begin
      stepped = cand[15:0];
    end
  end

  always_comb begin
    step    = STEP_FINE;
    step_dn = 1'b0;
    step_en = 1'b0;
    duty_o  = ctl_i.duty;
    if (diff > T08) begin
      duty_o = ctl_i.period;
    end else if (diff < -T08) begin
      duty_o = 16'd0;
    end else if (diff > T05) begin
      duty_o = half_up;
    end else if (diff < -T05) begin
      duty_o = half_dn;
    end else if (diff > T02) begin
      step = STEP_BIG;
      step_en = 1'b1;
    end else if (diff < -T02 && down_ok) begin
      step = STEP_BIG;
      step_dn = 1'b1;
      step_en = 1'b1;
    end else if (diff > T01) begin
      step = STEP_MID;
      step_en = 1'b1;
    end else if (diff < -T01 && down_ok) begin
      step = STEP_MID;
      step_dn = 1'b1;
      step_en = 1'b1;
    end else if (diff > T005) begin
      step_en = 1'b1;
    end else if (diff < -T005 && down_ok) begin
      step_dn = 1'b1;
      step_en = 1'b1;
    end
    if (step_en) begin
      duty_o = stepped;
    end
  end

endmodule

// File: design/bmvr_checker.sv
// Port-level checks for banded_motor_voltage_regulator_core, with bind.
// Depends on the top level's port list only.
module bmvr_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata
);

  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result pending after reset");

  a_in_gives_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> out_tvalid)
    else $error("input transaction without result");

  a_stall_blocks_in: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |-> !in_tready)
    else $error("input taken while result stalled");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  a_mean_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[31:16] <= 16'd65520)
    else $error("mean out of range");

endmodule

bind banded_motor_voltage_regulator_core bmvr_checker u_bmvr_checker (.*);
